@@ rtl/whc_pkg.sv @@
// whc_pkg: shared constants, payload structs, sequencer states and the cordic angle table
// used by every module of the waypoint heading controller; depends on nothing
package whc_pkg;

    localparam int CORDIC_STEPS = 16;   // 8 .. 30
    localparam int CNT_W        = 5;    // holds any step index up to 31
    localparam int CW           = 38;   // cordic x / y width
    localparam int ZW           = 28;   // angle width, 1/65536 degree
    localparam int SQW          = 58;   // squared distance width
    localparam int RTW          = 29;   // square root width
    localparam int RT_STEPS     = 29;   // root bit pairs

    localparam logic signed [ZW-1:0] DEG_180 = 28'sd11796480;
    localparam logic signed [ZW-1:0] DEG_90  = 28'sd5898240;
    localparam logic signed [ZW-1:0] DEG_4   = 28'sd262144;
    localparam logic signed [ZW-1:0] DEG_3   = 28'sd196608;
    localparam logic signed [31:0]   K_RAD   = 32'sd74961320;
    localparam logic [SQW-1:0]       D2_STOP  = 58'd42949672;
    localparam logic [SQW-1:0]       D2_REACH = 58'd1073741824;
    localparam logic signed [32:0]   FAR_LIM  = 33'sd268435456;
    localparam logic [30:0]          LIN_MAX  = 31'h7fffffff;

    localparam logic signed [31:0] TARGET_X_RESET = -32'sd1310720;
    localparam logic signed [31:0] TARGET_Y_RESET = 32'sd983040;

    localparam logic REG_TARGET_X = 1'b0;
    localparam logic REG_TARGET_Y = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } odom_t;

    typedef struct packed {
        logic [30:0]        linear_velocity;
        logic signed [31:0] angular_velocity;
        logic               reached;
        logic signed [15:0] turn_angle;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_CORD_YAW,
        ST_CORD_BRG,
        ST_TURN,
        ST_SCALE,
        ST_ROOT,
        ST_FIN
    } seq_state_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 28'sd2949120;
                5'd1:    v = 28'sd1740967;
                5'd2:    v = 28'sd919879;
                5'd3:    v = 28'sd466945;
                5'd4:    v = 28'sd234379;
                5'd5:    v = 28'sd117304;
                5'd6:    v = 28'sd58666;
                5'd7:    v = 28'sd29335;
                5'd8:    v = 28'sd14668;
                5'd9:    v = 28'sd7334;
                5'd10:   v = 28'sd3667;
                5'd11:   v = 28'sd1833;
                5'd12:   v = 28'sd917;
                5'd13:   v = 28'sd458;
                5'd14:   v = 28'sd229;
                5'd15:   v = 28'sd115;
                5'd16:   v = 28'sd57;
                5'd17:   v = 28'sd29;
                5'd18:   v = 28'sd14;
                5'd19:   v = 28'sd7;
                5'd20:   v = 28'sd4;
                5'd21:   v = 28'sd2;
                5'd22:   v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/whc_cordic.sv @@
// whc_cordic: iterative cordic vectoring unit, one micro-rotation per cycle
// depends on whc_pkg for widths, step count and the angle table
module whc_cordic
    import whc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic                 busy,
    output logic                 done,
    output logic signed [ZW-1:0] angle
);

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg, zero_reg;
    logic signed [CW-1:0] x_sh, y_sh;

    assign x_sh = x_reg >>> cnt_reg;
    assign y_sh = y_reg >>> cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                // pre-rotate into the right half plane
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= DEG_90;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -DEG_90;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_entry(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_entry(cnt_reg);
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_reg;

endmodule

@@ rtl/whc_isqrt.sv @@
// whc_isqrt: bit-pair integer square root, one result bit per cycle
// depends on whc_pkg for widths and step count
module whc_isqrt
    import whc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQW-1:0]   value,
    output logic             busy,
    output logic [RTW-1:0]   root
);

    logic [SQW-1:0]   v_reg, r_reg, b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [SQW-1:0]   trial;

    assign trial = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(RT_STEPS - 1))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= '0;
            b_reg <= SQW'(1) << (2 * (RT_STEPS - 1));
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
                r_reg <= r_reg >> 1;
            b_reg <= b_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[RTW-1:0];

endmodule

@@ rtl/waypoint_heading_controller.sv @@
// waypoint_heading_controller: top level, sequencer, shared multiplier and config registers
// depends on whc_pkg, whc_cordic and whc_isqrt
// per sample: multiply steps, prep, yaw and bearing cordic passes with the square root beside them,
//   then the turn, scale, root wait and finish states
// one sample at a time: a new one is taken only in idle, after the last result is loaded for output;
//   reset: targets return to (-20.0, 15.0), held rate and reached flag clear
module waypoint_heading_controller
    import whc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  odom_t       in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output cmd_t        out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    seq_state_t state_reg, state_next;

    // configuration
    logic signed [31:0] target_x_reg, target_y_reg;

    // captured sample
    odom_t in_reg;

    // controller state
    logic signed [31:0] held_reg;
    logic               reached_reg;

    // result register
    logic  out_valid_reg;
    cmd_t  out_reg;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic [2:0]         mstep_reg;

    // products and intermediates
    logic signed [31:0] p_wz_reg, p_xy_reg;
    logic [31:0]        p_yy_reg, p_zz_reg;
    logic [56:0]        sq_x_reg, sq_y_reg;
    logic [SQW-1:0]     d2_reg;
    logic               far_reg;
    logic signed [ZW-1:0] yaw_reg;
    logic signed [ZW:0]   turn_reg;
    logic signed [31:0]   ang_reg;
    logic signed [15:0]   ta_reg;

    // position error
    logic signed [32:0] ex, ey, bx, by;
    logic               far_now;

    assign ex = 33'(in_reg.pos_x) - 33'(target_x_reg);
    assign ey = 33'(in_reg.pos_y) - 33'(target_y_reg);
    assign bx = -ex;
    assign by = -ey;
    assign far_now = (ex >= FAR_LIM) || (ex <= -FAR_LIM) || (ey >= FAR_LIM) || (ey <= -FAR_LIM);

    // yaw vector
    logic signed [32:0] num_sum;
    logic [32:0]        den_sum;
    logic signed [33:0] num, den;

    assign num_sum = 33'(p_wz_reg) + 33'(p_xy_reg);
    assign den_sum = {1'b0, p_yy_reg} + {1'b0, p_zz_reg};
    assign num     = {num_sum, 1'b0};
    assign den     = 34'sd268435456 - $signed({den_sum, 1'b0});

    // cordic hookup: yaw vector first, bearing second
    logic                 c_start, c_busy, c_done;
    logic signed [CW-1:0] c_x, c_y;
    logic signed [ZW-1:0] c_angle;

    always_comb
    begin
        c_start = (state_reg == ST_PREP) || (state_reg == ST_CORD_YAW && c_done);
        if (state_reg == ST_PREP)
        begin
            c_x = CW'(den);
            c_y = CW'(num);
        end
        else if (bx > 0)
        begin
            c_x = CW'(bx);
            c_y = CW'(by);
        end
        else
        begin
            c_x = -CW'(bx);
            c_y = -CW'(by);
        end
    end

    whc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .x_in  (c_x),
        .y_in  (c_y),
        .busy  (c_busy),
        .done  (c_done),
        .angle (c_angle)
    );

    // square root of the squared distance, runs beside the cordic
    logic            r_start, r_busy;
    logic [RTW-1:0]  r_root;
    logic [SQW-1:0]  d2_now;

    assign d2_now  = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign r_start = (state_reg == ST_PREP);

    whc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (r_start),
        .value (d2_now),
        .busy  (r_busy),
        .root  (r_root)
    );

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_TURN)
        begin
            mul_a = 32'(turn_reg);
            mul_b = K_RAD;
        end
        else
        begin
            case (mstep_reg)
                3'd0:
                begin
                    mul_a = 32'(in_reg.quat_w);
                    mul_b = 32'(in_reg.quat_z);
                end
                3'd1:
                begin
                    mul_a = 32'(in_reg.quat_x);
                    mul_b = 32'(in_reg.quat_y);
                end
                3'd2:
                begin
                    mul_a = 32'(in_reg.quat_y);
                    mul_b = 32'(in_reg.quat_y);
                end
                3'd3:
                begin
                    mul_a = 32'(in_reg.quat_z);
                    mul_b = 32'(in_reg.quat_z);
                end
                3'd4:
                begin
                    // only the low bits matter when the goal is near
                    mul_a = 32'($signed(ex[28:0]));
                    mul_b = 32'($signed(ex[28:0]));
                end
                3'd5:
                begin
                    mul_a = 32'($signed(ey[28:0]));
                    mul_b = 32'($signed(ey[28:0]));
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // heading flip and bearing
    logic signed [ZW-1:0] yaw_flip, theta;

    always_comb
    begin
        yaw_flip = c_angle;
        if (in_reg.pos_x < target_x_reg)
            yaw_flip = (c_angle > 0) ? c_angle - DEG_180 : c_angle + DEG_180;
        if (bx == 0)
            theta = (by > 0) ? DEG_90 : ((by < 0) ? -DEG_90 : '0);
        else
            theta = c_angle;
    end

    // scaling of the heading error: times 500 as shift-adds for the rate, and both outputs round half up
    logic signed [63:0] p500, ang_wide, ta_wide;

    assign p500     = (prod_reg <<< 9) - (prod_reg <<< 3) - (prod_reg <<< 2);
    assign ang_wide = (p500 + 64'sd2147483648) >>> 32;
    assign ta_wide  = (prod_reg + 64'sd34359738368) >>> 36;

    // final command decision
    logic signed [ZW:0] aturn;
    logic               stop, small_turn;
    logic [32:0]        lin10;
    logic [30:0]        lin_calc, lin_new;
    logic signed [31:0] held_new;
    logic               reached_new;

    always_comb
    begin
        aturn      = (turn_reg < 0) ? -turn_reg : turn_reg;
        stop       = !far_reg && (d2_reg <= D2_STOP);
        small_turn = aturn < (ZW+1)'(DEG_4);
        lin10      = {1'b0, r_root, 3'b000} + {3'b000, r_root, 1'b0};
        if (far_reg || lin10 > 33'(LIN_MAX))
            lin_calc = LIN_MAX;
        else
            lin_calc = lin10[30:0];
        if (stop)
        begin
            lin_new  = '0;
            held_new = '0;
        end
        else if (small_turn)
        begin
            lin_new  = lin_calc;
            // between three and four degrees the last turn rate stays
            held_new = (aturn < (ZW+1)'(DEG_3)) ? '0 : held_reg;
        end
        else
        begin
            lin_new  = '0;
            held_new = ang_reg;
        end
        reached_new = reached_reg || (!far_reg && d2_reg < D2_REACH);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL;
            ST_MUL:      if (mstep_reg == 3'd6) state_next = ST_PREP;
            ST_PREP:     state_next = ST_CORD_YAW;
            ST_CORD_YAW: if (c_done) state_next = ST_CORD_BRG;
            ST_CORD_BRG: if (c_done) state_next = ST_TURN;
            ST_TURN:     state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_ROOT;
            ST_ROOT:     if (!r_busy) state_next = ST_FIN;
            ST_FIN:      if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_x_reg  <= TARGET_X_RESET;
            target_y_reg  <= TARGET_Y_RESET;
            held_reg      <= '0;
            reached_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mstep_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET_X: target_x_reg <= cfg_data;
                    REG_TARGET_Y: target_y_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (state_reg == ST_MUL)
                mstep_reg <= mstep_reg + 1'b1;
            else
                mstep_reg <= '0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                held_reg      <= held_new;
                reached_reg   <= reached_new;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_IDLE && in_valid)
            in_reg <= in_data;
        if (state_reg == ST_MUL)
        begin
            case (mstep_reg)
                3'd1:    p_wz_reg <= prod_reg[31:0];
                3'd2:    p_xy_reg <= prod_reg[31:0];
                3'd3:    p_yy_reg <= prod_reg[31:0];
                3'd4:    p_zz_reg <= prod_reg[31:0];
                3'd5:    sq_x_reg <= prod_reg[56:0];
                3'd6:    sq_y_reg <= prod_reg[56:0];
                default: ;
            endcase
        end
        if (state_reg == ST_PREP)
        begin
            d2_reg  <= d2_now;
            far_reg <= far_now;
        end
        if (state_reg == ST_CORD_YAW && c_done)
            yaw_reg <= yaw_flip;
        if (state_reg == ST_CORD_BRG && c_done)
            turn_reg <= (ZW+1)'(yaw_reg) - (ZW+1)'(theta);
        if (state_reg == ST_SCALE)
        begin
            if (ang_wide > 64'sd2147483647)
                ang_reg <= 32'sh7fffffff;
            else if (ang_wide < -64'sd2147483648)
                ang_reg <= 32'sh80000000;
            else
                ang_reg <= ang_wide[31:0];
            if (ta_wide > 64'sd32767)
                ta_reg <= 16'sh7fff;
            else if (ta_wide < -64'sd32768)
                ta_reg <= 16'sh8000;
            else
                ta_reg <= ta_wide[15:0];
        end
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            out_reg.linear_velocity  <= lin_new;
            out_reg.angular_velocity <= held_new;
            out_reg.reached          <= reached_new;
            out_reg.turn_angle       <= ta_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // one sample at a time: after an input transfer the sequencer is busy
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while sample in flight");

    // reached flag never drops once set
    a_reached_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        reached_reg |=> reached_reg)
        else $error("reached flag cleared");

    // the cordic is running whenever the sequencer waits on it for the bearing
    a_cordic_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORD_BRG) && !c_done |-> c_busy)
        else $error("bearing wait without cordic activity");

    // drive only when the heading error is small
    a_drive_small_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && (lin_new != '0) |-> small_turn)
        else $error("drive command with large heading error");
`endif

endmodule
